@@ design/rotated_sprite_quad_expand_macros.svh @@
// Assertion macros for the sprite quad expander.
`ifndef ROTATED_SPRITE_QUAD_EXPAND_MACROS_SVH
`define ROTATED_SPRITE_QUAD_EXPAND_MACROS_SVH
`ifndef SYNTHESIS
`define RSQE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rsqe: implication check failed");
`define RSQE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rsqe: next-cycle check failed");
`else
`define RSQE_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define RSQE_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ design/rsqe_pkg.sv @@
// Types and constants shared by the sprite quad expander.
package rsqe_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int TEX_SIZE_MAX = 4096;
  localparam int CFG_W        = 13;
  localparam int DW           = $clog2(TEX_SIZE_MAX + 1);

  localparam int SIN_A = 102944;
  localparam int SIN_B = 42048;
  localparam int SIN_C = 4640;
  localparam int ONE_Q14 = 16384;

  typedef enum logic {
    REG_TEX_WIDTH  = 1'b0,
    REG_TEX_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic signed [23:0] center_x;
    logic signed [23:0] center_y;
    logic [15:0]        angle;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic [15:0]        uv_left;
    logic [15:0]        uv_top;
    logic [15:0]        uv_right;
    logic [15:0]        uv_bottom;
    logic [31:0]        rgba;
  } sprite_t;

  typedef struct packed {
    logic signed [23:0] vertex_x;
    logic signed [23:0] vertex_y;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic [31:0]        vertex_color;
    logic [1:0]         corner_index;
    logic               last_vertex;
  } vertex_t;

endpackage

@@ design/rsqe_sprite_if.sv @@
// Particle item channel.
interface rsqe_sprite_if import rsqe_pkg::*; ();
  logic    valid;
  logic    ready;
  sprite_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/rsqe_vertex_if.sv @@
// Vertex item channel.
interface rsqe_vertex_if import rsqe_pkg::*; ();
  logic    valid;
  logic    ready;
  vertex_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/rotated_sprite_quad_expand.sv @@
// Sprite quad expander: one particle in, four rotated textured vertices out.
// Particles can enter while earlier ones expand, via the front pipe and the corner register.
// Throughput: one vertex per cycle on the single vertex lane, held while vtx.ready is low.
// Sine/cosine run in a five-stage front pipe, vertices in a seven-stage pipe with the divider.
// Reset (rst, synchronous): pipes empty, texture sizes return to 256.
`include "rotated_sprite_quad_expand_macros.svh"
module rotated_sprite_quad_expand import rsqe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  rsqe_sprite_if.sink sprite,
  rsqe_vertex_if.source vtx,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AB     = ANGLE_BITS;
  localparam int ANG_UP = (AB >= 16) ? AB - 16 : 0;
  localparam int ANG_DN = (AB < 16) ? 16 - AB : 0;
  localparam int Z_UP   = (AB <= 18) ? 18 - AB : 0;
  localparam int Z_DN   = (AB > 18) ? AB - 18 : 0;
  localparam logic [AB-1:0] QUARTER = AB'(1) << (AB - 2);
  localparam int FS = 5;
  localparam int VS = 7;
  localparam int NW = 28;
  localparam int TW = DW + 17;

  typedef struct packed {
    logic [1:0][16:0]   z;
    logic [1:0]         neg;
    logic [1:0][16:0]   z2;
    logic [1:0][15:0]   tb;
    logic [1:0][16:0]   ta;
    logic signed [15:0] sn;
    logic signed [15:0] cs;
    logic signed [16:0] hw;
    logic signed [16:0] hh;
    logic signed [32:0] bx;
    logic signed [32:0] by;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic [15:0]        ul;
    logic [15:0]        ut;
    logic [15:0]        ur;
    logic [15:0]        ub;
    logic [31:0]        color;
  } ft_t;

  typedef struct packed {
    logic signed [48:0] pxc;
    logic signed [48:0] pys;
    logic signed [48:0] pxs;
    logic signed [48:0] pyc;
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic signed [30:0] rx;
    logic signed [30:0] ry;
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic [NW-1:0]      ru;
    logic [NW-1:0]      rv;
    logic [16:0]        qu;
    logic [16:0]        qv;
    logic               clu;
    logic               clv;
    logic [31:0]        color;
    logic [1:0]         k;
  } vp_t;

  // configuration
  logic [CFG_W-1:0] tex_w;
  logic [CFG_W-1:0] tex_h;
  logic [DW-1:0]    dw;
  logic [DW-1:0]    dh;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_w <= CFG_W'(256);
      tex_h <= CFG_W'(256);
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx_t'(paddr[2]))
        REG_TEX_WIDTH:  tex_w <= pwdata[CFG_W-1:0];
        REG_TEX_HEIGHT: tex_h <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[2]))
      REG_TEX_WIDTH:  prdata = 32'(tex_w);
      REG_TEX_HEIGHT: prdata = 32'(tex_h);
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    if (tex_w == '0) dw = DW'(1);
    else if (32'(tex_w) > TEX_SIZE_MAX) dw = DW'(TEX_SIZE_MAX);
    else dw = DW'(tex_w);
    if (tex_h == '0) dh = DW'(1);
    else if (32'(tex_h) > TEX_SIZE_MAX) dh = DW'(TEX_SIZE_MAX);
    else dh = DW'(tex_h);
  end

  // flow control
  logic          en;
  logic          front_adv;
  logic          load;
  logic [FS-1:0] fv;
  ft_t           f [FS];
  ft_t           fn [FS];
  logic          ev;
  logic [1:0]    ecnt;
  ft_t           e;
  logic [VS-1:0] vv;
  vp_t           vp [VS];
  vp_t           vn [VS];

  assign en        = !vv[VS-1] || vtx.ready;
  assign front_adv = en && (!fv[FS-1] || !ev || ecnt == 2'd3);
  assign load      = front_adv && fv[FS-1];
  assign sprite.ready = front_adv;

  // front pipe: half extents and sine/cosine polynomial
  logic [AB-1:0] phase;
  logic [AB-1:0] ph;
  logic [AB-3:0] xq;
  logic [AB-2:0] xx;
  logic [29:0]   p30;
  logic [32:0]   p33;
  logic [33:0]   p34;
  logic [17:0]   r18;
  logic [16:0]   rr;

  always_comb begin
    for (int s = 0; s < FS; s++) fn[s] = f[s];
    phase = AB'((32'(sprite.data.angle) << ANG_UP) >> ANG_DN);
    ph = '0;
    xq = '0;
    xx = '0;
    p30 = '0;
    p33 = '0;
    p34 = '0;
    r18 = '0;
    rr = '0;
    for (int l = 0; l < 2; l++) begin
      ph = (l == 0) ? phase : phase + QUARTER;
      xq = ph[AB-3:0];
      xx = ph[AB-2] ? (AB-1)'(QUARTER) - (AB-1)'(xq) : (AB-1)'(xq);
      fn[0].z[l]   = 17'((32'(xx) << Z_UP) >> Z_DN);
      fn[0].neg[l] = ph[AB-1];
    end
    fn[0].hw    = 17'(sprite.data.uv_right) - 17'(sprite.data.uv_left);
    fn[0].hh    = 17'(sprite.data.uv_bottom) - 17'(sprite.data.uv_top);
    fn[0].sx    = sprite.data.scale_x;
    fn[0].sy    = sprite.data.scale_y;
    fn[0].cx    = sprite.data.center_x;
    fn[0].cy    = sprite.data.center_y;
    fn[0].ul    = sprite.data.uv_left;
    fn[0].ut    = sprite.data.uv_top;
    fn[0].ur    = sprite.data.uv_right;
    fn[0].ub    = sprite.data.uv_bottom;
    fn[0].color = sprite.data.rgba;

    fn[1] = f[0];
    for (int l = 0; l < 2; l++)
      fn[1].z2[l] = 17'((34'(f[0].z[l]) * 34'(f[0].z[l])) >> 16);
    fn[1].bx = 33'(f[0].hw) * 33'(f[0].sx);
    fn[1].by = 33'(f[0].hh) * 33'(f[0].sy);

    fn[2] = f[1];
    for (int l = 0; l < 2; l++) begin
      p30 = 30'(SIN_C) * 30'(f[1].z2[l]);
      fn[2].tb[l] = 16'(SIN_B) - 16'(p30 >> 16);
    end

    fn[3] = f[2];
    for (int l = 0; l < 2; l++) begin
      p33 = 33'(f[2].tb[l]) * 33'(f[2].z2[l]);
      fn[3].ta[l] = 17'(SIN_A) - 17'(p33 >> 16);
    end

    fn[4] = f[3];
    for (int l = 0; l < 2; l++) begin
      p34 = 34'(f[3].z[l]) * 34'(f[3].ta[l]);
      r18 = 18'(p34 >> 16);
      rr  = 17'((19'(r18) + 19'd2) >> 2);
      if (32'(rr) > ONE_Q14) rr = 17'(ONE_Q14);
      if (l == 0) fn[4].sn = f[3].neg[l] ? -$signed(16'(rr)) : $signed(16'(rr));
      else        fn[4].cs = f[3].neg[l] ? -$signed(16'(rr)) : $signed(16'(rr));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= '0;
    end else if (front_adv) begin
      fv <= {fv[FS-2:0], sprite.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (front_adv) begin
      for (int s = 0; s < FS; s++) f[s] <= fn[s];
    end
  end

  // corner sequencer: holds one particle for four vertex slots
  always_ff @(posedge clk) begin
    if (rst) begin
      ev   <= 1'b0;
      ecnt <= '0;
    end else begin
      if (en && ev) begin
        ecnt <= ecnt + 2'd1;
        if (ecnt == 2'd3) ev <= 1'b0;
      end
      if (load) ev <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) e <= f[FS-1];
  end

  // vertex pipe: rotate, translate, round, saturate; texel divide alongside
  logic signed [32:0] x_sel;
  logic signed [32:0] y_sel;
  logic [15:0]        ue;
  logic [15:0]        ve;
  logic [TW-1:0]      lim;
  logic [TW-1:0]      trial;
  logic signed [49:0] sx_sum;
  logic signed [49:0] sy_sum;
  int                 bi;

  always_comb begin
    for (int s = 0; s < VS; s++) vn[s] = vp[s];
    x_sel = (ecnt == 2'd0 || ecnt == 2'd3) ? -e.bx : e.bx;
    y_sel = (ecnt == 2'd0 || ecnt == 2'd1) ? -e.by : e.by;
    ue    = (ecnt == 2'd0 || ecnt == 2'd3) ? e.ul : e.ur;
    ve    = (ecnt == 2'd0 || ecnt == 2'd1) ? e.ub : e.ut;
    vn[0].pxc   = 49'(x_sel) * 49'(e.cs);
    vn[0].pys   = 49'(y_sel) * 49'(e.sn);
    vn[0].pxs   = 49'(x_sel) * 49'(e.sn);
    vn[0].pyc   = 49'(y_sel) * 49'(e.cs);
    vn[0].cx    = e.cx;
    vn[0].cy    = e.cy;
    vn[0].color = e.color;
    vn[0].k     = ecnt;
    vn[0].ru    = {ue, 12'd0};
    vn[0].rv    = {ve, 12'd0};
    vn[0].qu    = '0;
    vn[0].qv    = '0;
    lim = (TW'(dw) << 16) + TW'(dw);
    vn[0].clu = TW'(vn[0].ru) >= lim;
    lim = (TW'(dh) << 16) + TW'(dh);
    vn[0].clv = TW'(vn[0].rv) >= lim;

    sx_sum = '0;
    sy_sum = '0;
    trial  = '0;
    bi     = 0;
    for (int s = 1; s < VS; s++) begin
      vn[s] = vp[s-1];
      if (s == 1) begin
        sx_sum = 50'(vp[0].pxc) - 50'(vp[0].pys) + (50'(vp[0].cx) <<< 19)
                 + (50'sd1 <<< 18);
        sy_sum = 50'(vp[0].pxs) + 50'(vp[0].pyc) + (50'(vp[0].cy) <<< 19)
                 + (50'sd1 <<< 18);
        vn[s].rx = 31'(sx_sum >>> 19);
        vn[s].ry = 31'(sy_sum >>> 19);
      end
      if (s == 2) begin
        if (vp[1].rx > 31'sd8388607) vn[s].vx = 24'sh7FFFFF;
        else if (vp[1].rx < -31'sd8388608) vn[s].vx = 24'sh800000;
        else vn[s].vx = vp[1].rx[23:0];
        if (vp[1].ry > 31'sd8388607) vn[s].vy = 24'sh7FFFFF;
        else if (vp[1].ry < -31'sd8388608) vn[s].vy = 24'sh800000;
        else vn[s].vy = vp[1].ry[23:0];
      end
      for (int j = 0; j < 3; j++) begin
        bi = 16 - 3 * (s - 1) - j;
        if (bi >= 0) begin
          trial = TW'(dw) << bi;
          if (TW'(vn[s].ru) >= trial) begin
            vn[s].ru = vn[s].ru - NW'(trial);
            vn[s].qu = vn[s].qu | (17'd1 << bi);
          end
          trial = TW'(dh) << bi;
          if (TW'(vn[s].rv) >= trial) begin
            vn[s].rv = vn[s].rv - NW'(trial);
            vn[s].qv = vn[s].qv | (17'd1 << bi);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vv <= '0;
    end else if (en) begin
      vv <= {vv[VS-2:0], ev};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < VS; s++) vp[s] <= vn[s];
    end
  end

  assign vtx.valid = vv[VS-1];
  assign vtx.data.vertex_x     = vp[VS-1].vx;
  assign vtx.data.vertex_y     = vp[VS-1].vy;
  assign vtx.data.tex_u        = vp[VS-1].clu ? 17'd65536 : vp[VS-1].qu;
  assign vtx.data.tex_v        = vp[VS-1].clv ? 17'd65536 : vp[VS-1].qv;
  assign vtx.data.vertex_color = vp[VS-1].color;
  assign vtx.data.corner_index = vp[VS-1].k;
  assign vtx.data.last_vertex  = (vp[VS-1].k == 2'd3);

  `RSQE_ASSERT_IMP(a_load_free, clk, rst, load, !ev || (en && ecnt == 2'd3))
  `RSQE_ASSERT_NXT(a_seq_hold, clk, rst, ev && !(en && ecnt == 2'd3), ev)
  `RSQE_ASSERT_NXT(a_cnt_step, clk, rst, en && ev, ecnt == $past(ecnt) + 2'd1)
  `RSQE_ASSERT_IMP(a_sine_range, clk, rst, fv[FS-1], f[FS-1].sn <= 16'sd16384 && f[FS-1].sn >= -16'sd16384)
  `RSQE_ASSERT_IMP(a_quot_range, clk, rst, vv[VS-1] && !vp[VS-1].clu, vp[VS-1].qu <= 17'd65536)

endmodule

@@ verif/rotated_sprite_quad_expand_test.sv @@
// Testbench for the sprite quad expander: directed and random particles, checked vertex by vertex.
module rotated_sprite_quad_expand_test import rsqe_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  class quad_scoreboard;
    vertex_t pending_vertices[$];
    int unsigned tex_width_eff;
    int unsigned tex_height_eff;
    int mismatches;
    int vertices_checked;

    function new();
      tex_width_eff = 256;
      tex_height_eff = 256;
      mismatches = 0;
      vertices_checked = 0;
    endfunction

    function void set_size(reg_idx_t idx, logic [31:0] value);
      int unsigned v;
      v = value & 32'h1FFF;
      if (v == 0) v = 1;
      if (v > TEX_SIZE_MAX) v = TEX_SIZE_MAX;
      if (idx == REG_TEX_WIDTH) tex_width_eff = v;
      else tex_height_eff = v;
    endfunction

    function longint quarter_wave(longint unsigned x);
      longint unsigned z, z2, t, r;
      z = x << (18 - ANGLE_BITS);
      z2 = (z * z) >> 16;
      t = (SIN_C * z2) >> 16;
      t = SIN_B - t;
      t = (t * z2) >> 16;
      t = SIN_A - t;
      r = (z * t) >> 16;
      r = (r + 2) >> 2;
      if (r > ONE_Q14) r = ONE_Q14;
      return longint'(r);
    endfunction

    function longint sine_q14(longint unsigned phase);
      longint unsigned quarter, q, x;
      longint v;
      quarter = 64'd1 << (ANGLE_BITS - 2);
      phase &= (64'd1 << ANGLE_BITS) - 1;
      q = phase >> (ANGLE_BITS - 2);
      x = phase & (quarter - 1);
      v = q[0] ? quarter_wave(quarter - x) : quarter_wave(x);
      return q[1] ? -v : v;
    endfunction

    function logic [23:0] round_sat(longint v);
      longint w, r;
      w = v + (64'sd1 << 18);
      r = w >>> 19;
      if (r > 8388607) r = 8388607;
      if (r < -8388608) r = -8388608;
      return r[23:0];
    endfunction

    function logic [16:0] normalise(longint unsigned edge_texels, int unsigned size);
      longint unsigned r;
      r = (edge_texels << 12) / size;
      if (r > 65536) r = 65536;
      return r[16:0];
    endfunction

    function void note_sprite(sprite_t s);
      longint sn, cs, hw, hh, x, y;
      longint unsigned ph;
      vertex_t v;
      ph = longint'(s.angle) << (ANGLE_BITS - 16);
      sn = sine_q14(ph);
      cs = sine_q14(ph + (64'd1 << (ANGLE_BITS - 2)));
      hw = longint'(s.uv_right) - longint'(s.uv_left);
      hh = longint'(s.uv_bottom) - longint'(s.uv_top);
      for (int k = 0; k < 4; k++) begin
        x = ((k == 0 || k == 3) ? -hw : hw) * longint'(s.scale_x);
        y = ((k < 2) ? -hh : hh) * longint'(s.scale_y);
        v.vertex_x = round_sat(x * cs - y * sn + longint'(s.center_x) * (64'sd1 << 19));
        v.vertex_y = round_sat(x * sn + y * cs + longint'(s.center_y) * (64'sd1 << 19));
        v.tex_u = normalise((k == 0 || k == 3) ? s.uv_left : s.uv_right, tex_width_eff);
        v.tex_v = normalise((k < 2) ? s.uv_bottom : s.uv_top, tex_height_eff);
        v.vertex_color = s.rgba;
        v.corner_index = k[1:0];
        v.last_vertex = (k == 3);
        pending_vertices.push_back(v);
      end
    endfunction

    function void check_vertex(vertex_t got);
      vertex_t exp_v;
      if (pending_vertices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected vertex %p", got);
        return;
      end
      exp_v = pending_vertices.pop_front();
      vertices_checked++;
      if (got !== exp_v) begin
        mismatches++;
        if (mismatches <= 10) $display("vertex mismatch: expected %p got %p", exp_v, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  rsqe_sprite_if sprite_ch();
  rsqe_vertex_if vtx_ch();

  rotated_sprite_quad_expand u_dut (
    .clk(clk), .rst(rst), .sprite(sprite_ch.sink), .vtx(vtx_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  quad_scoreboard board = new();
  bit calm_tail = 0;
  bit hold_sink = 0;
  int sprites_sent = 0;

  initial begin
    sprite_ch.valid = 1'b0;
    sprite_ch.data = '0;
    vtx_ch.ready = 1'b0;
  end

  initial begin
    int burst;
    @(posedge clk);
    while (1) begin
      if (hold_sink) begin
        vtx_ch.ready <= 1'b0;
        @(posedge clk);
      end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 19);
        vtx_ch.ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end else begin
        vtx_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && vtx_ch.valid && vtx_ch.ready) board.check_vertex(vtx_ch.data);
  end

  task automatic write_size(reg_idx_t idx, logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 3'(idx) << 2; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    board.set_size(idx, value);
    @(posedge clk);
  endtask

  task automatic send_sprite(sprite_t s);
    if (!calm_tail && $urandom_range(0, 4) == 0) begin
      sprite_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    sprite_ch.valid <= 1'b1;
    sprite_ch.data <= s;
    @(posedge clk);
    while (!sprite_ch.ready) @(posedge clk);
    board.note_sprite(s);
    sprites_sent++;
  endtask

  task automatic go_idle();
    sprite_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending_vertices.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic sprite_t random_sprite();
    sprite_t s;
    s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if ($urandom_range(0, 2) != 0) begin
      s.center_x = $signed(24'($urandom_range(0, 65535))) - 24'sd32768;
      s.center_y = $signed(24'($urandom_range(0, 65535))) - 24'sd32768;
      s.scale_x = $signed(16'($urandom_range(0, 1023))) - 16'sd512;
      s.scale_y = $signed(16'($urandom_range(0, 1023))) - 16'sd512;
      s.uv_left = 16'($urandom_range(0, 8191));
      s.uv_top = 16'($urandom_range(0, 8191));
      s.uv_right = s.uv_left + 16'($urandom_range(0, 1023));
      s.uv_bottom = s.uv_top + 16'($urandom_range(0, 1023));
    end
    return s;
  endfunction

  function automatic sprite_t make_sprite(logic [23:0] cx, logic [23:0] cy, logic [15:0] ang,
                                          logic [15:0] sx, logic [15:0] sy, logic [15:0] ul,
                                          logic [15:0] ut, logic [15:0] ur, logic [15:0] ub);
    sprite_t s;
    s = '{cx, cy, ang, sx, sy, ul, ut, ur, ub, $urandom};
    return s;
  endfunction

  initial begin
    logic [31:0] sizes[6];
    sizes = '{32'd1, 32'd0, 32'd4096, 32'h1FFF, 32'd4097, 32'd100};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_sprite(make_sprite(0, 0, 0, 16'h0100, 16'h0100, 0, 0, 16'h0100, 16'h0100));
    for (int a = 0; a < 8; a++)
      send_sprite(make_sprite(24'h001000, 24'hFFF000, 16'(a * 16'h2000 + (a & 1)),
                              16'h0180, 16'hFF00, 16'h0040, 16'h0080, 16'h0300, 16'h0200));
    send_sprite(make_sprite(24'h7FFFFF, 24'h800000, 16'hFFFF, 16'h7FFF, 16'h8000,
                            16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF));
    send_sprite(make_sprite(24'h800000, 24'h7FFFFF, 16'h4000, 16'h8000, 16'h7FFF,
                            16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000));
    send_sprite(make_sprite(24'h000123, 24'h000456, 16'h1234, 16'h0100, 16'h0100,
                            16'h0500, 16'h0600, 16'h0100, 16'h0200));
    send_sprite(make_sprite(0, 0, 16'h2000, 0, 0, 16'hFFFF, 16'h0001, 16'hFFFE, 16'h0002));
    go_idle();

    foreach (sizes[i]) begin
      write_size(REG_TEX_WIDTH, sizes[i]);
      write_size(REG_TEX_HEIGHT, sizes[(i + 3) % 6]);
      send_sprite(make_sprite(0, 0, 0, 16'h0100, 16'h0100,
                              16'hFFFF, 16'h0000, 16'h0010, 16'h8000));
      for (int n = 0; n < 40; n++) send_sprite(random_sprite());
      if (i == 2) begin
        hold_sink = 1;
        fork
          begin
            repeat (300) @(posedge clk);
            hold_sink = 0;
          end
          for (int n = 0; n < 20; n++) send_sprite(random_sprite());
        join
      end
      go_idle();
    end

    write_size(REG_TEX_WIDTH, $urandom_range(1, 4096));
    write_size(REG_TEX_HEIGHT, $urandom_range(1, 4096));
    calm_tail = 1;
    for (int n = 0; n < 30; n++) send_sprite(random_sprite());
    go_idle();

    $display("Sent %0d particles over several texture sizes; %0d vertices checked.",
             sprites_sent, board.vertices_checked);
    if (board.mismatches == 0 && board.pending_vertices.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
